// ===== hdl/iua_pkg.sv =====
// Shared types, codes and a helper function for the inode usage accounting block.
`timescale 1ns / 1ps

package iua_pkg;

    // Inode mode type codes
    localparam logic [3:0] IFMT    = 4'hF;
    localparam logic [3:0] FT_FREE = 4'd0;
    localparam logic [3:0] IFCHR   = 4'd2;
    localparam logic [3:0] IFDIR   = 4'd4;
    localparam logic [3:0] IFBLK   = 4'd6;
    localparam logic [3:0] IFREG   = 4'd8;

    // Request codes
    localparam logic [1:0] REQ_ACCOUNT    = 2'd0;
    localparam logic [1:0] REQ_OWNER_READ = 2'd1;
    localparam logic [1:0] REQ_BIN_READ   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_VALID   = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_HIST_MODE  = 2'd0;
    localparam logic [1:0] CFG_AGE_FILTER = 2'd1;
    localparam logic [1:0] CFG_AGE_CUTOFF = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  file_type;
        logic [15:0] owner_id;
        logic [31:0] size_bytes;
        logic [31:0] access_time;
        logic [23:0] allocated_blocks;
        logic [15:0] read_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_or_bin_count;
        logic [31:0] file_count;
        logic [31:0] overflow_total;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef enum logic [2:0] {
        OP_SKIP,
        OP_OWNER_ADD,
        OP_HIST_ADD,
        OP_OWNER_READ,
        OP_BIN_READ,
        OP_RANGE
    } op_t;

    // 32-bit add that sticks at all ones
    function automatic logic [31:0] sat_add32(input logic [31:0] acc, input logic [31:0] add);
        logic [32:0] sum;
        sum = {1'b0, acc} + {1'b0, add};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

// ===== hdl/iua_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface iua_req_if import iua_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iua_rsp_if import iua_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/iua_div.sv =====
// Divider of a 32-bit value by a fixed constant: reciprocal multiply and one correction step.
`timescale 1ns / 1ps

module iua_div #(
    parameter int DIVISOR = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    output logic        done,
    output logic [31:0] quotient
);

    // floor(2^32 / DIVISOR); the estimate it gives is the quotient or one below it
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DIVISOR));
    localparam logic [31:0] DIV_C = 32'(DIVISOR);

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        done_reg;
    logic [31:0] num_reg;
    logic [31:0] est_reg;
    logic [31:0] rem_reg;
    logic [31:0] quot_reg;
    logic [63:0] prod;

    assign prod = {32'd0, num_reg} * {32'd0, RECIP};

    // Stage valids: load, estimate, remainder, correct
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Datapath; the remainder left by the estimate is below twice the divisor
    always_ff @(posedge clk)
    begin
        if (start)
            num_reg <= dividend;
        if (v1_reg)
            est_reg <= prod[63:32];
        if (v2_reg)
            rem_reg <= num_reg - est_reg * DIV_C;
        if (v3_reg)
            quot_reg <= est_reg + {31'd0, (rem_reg >= DIV_C)};
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== hdl/inode_usage_accounting.sv =====
// Top level: per-owner usage tables and file-size histogram in block memories.
// Owner and readout requests pass through the read and write-back states to the result register;
// histogram accounting first waits in the divide state on the constant divider for the bin.
// A new request is taken only in the idle state, after the last one's write-back; a full result
// register holds the write-back step until the result is taken.
// Reset: config registers and the oversize sum clear at once; a clearing pass then zeroes
// the memories one entry a cycle, over the depth of the larger memory, before requests are taken.
`timescale 1ns / 1ps

module inode_usage_accounting import iua_pkg::*; #(
    parameter int OWNER_SLOTS = 4096,
    parameter int HIST_BINS   = 512,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    iua_req_if.sink     req,
    iua_rsp_if.source   rsp
);

    localparam int OWN_AW    = $clog2(OWNER_SLOTS);
    localparam int BIN_AW    = $clog2(HIST_BINS);
    localparam int CLR_DEPTH = (OWNER_SLOTS > HIST_BINS) ? OWNER_SLOTS : HIST_BINS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Configuration registers
    logic        hist_mode_reg;
    logic        age_on_reg;
    logic [31:0] cutoff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_mode_reg <= 1'b0;
            age_on_reg    <= 1'b0;
            cutoff_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HIST_MODE:  hist_mode_reg <= cfg_data[0];
                CFG_AGE_FILTER: age_on_reg    <= cfg_data[0];
                CFG_AGE_CUTOFF: cutoff_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Control state
    state_t           state_reg, state_next;
    logic [CLR_W-1:0] clr_reg;
    logic             out_valid_reg;
    logic [31:0]      ovf_sum_reg;

    // Request registers
    op_t               op_reg;
    logic [OWN_AW-1:0] own_addr_reg;
    logic [BIN_AW-1:0] bin_addr_reg;
    logic [23:0]       add_blocks_reg;
    logic              size_zero_reg;
    logic              bin_ovf_reg;
    logic [31:0]       bin_val_reg;

    // Result registers
    rsp_t out_reg;
    rsp_t out_next;

    // FSM outputs
    logic in_ready;
    logic div_start;
    logic mem_re;
    logic wr_go;
    logic clr_active;

    logic        xfer_in;
    logic        div_done;
    logic [31:0] div_quot;
    logic        clr_last;
    op_t         op_dec;
    logic [31:0] div_dividend;
    logic [31:0] bin_calc;

    assign xfer_in  = req.valid && in_ready;
    assign clr_last = (clr_reg == CLR_W'(CLR_DEPTH - 1));

    // Request decode against the current configuration
    always_comb
    begin
        logic [3:0] ft;
        logic       aged_out;
        ft       = req.data.file_type & IFMT;
        aged_out = age_on_reg && (req.data.access_time > cutoff_reg);
        op_dec   = OP_SKIP;
        case (req.data.req_type)
            REQ_ACCOUNT:
            begin
                if (ft == FT_FREE || aged_out)
                    op_dec = OP_SKIP;
                else if (hist_mode_reg)
                    op_dec = (ft inside {IFDIR, IFREG}) ? OP_HIST_ADD : OP_SKIP;
                else if ({16'd0, req.data.owner_id} < 32'(OWNER_SLOTS))
                    op_dec = OP_OWNER_ADD;
                else
                    op_dec = OP_SKIP;
            end
            REQ_OWNER_READ:
                op_dec = ({16'd0, req.data.read_index} < 32'(OWNER_SLOTS)) ?
                         OP_OWNER_READ : OP_RANGE;
            REQ_BIN_READ:
                op_dec = ({16'd0, req.data.read_index} < 32'(HIST_BINS)) ?
                         OP_BIN_READ : OP_RANGE;
            default:
                op_dec = OP_SKIP;
        endcase
    end

    // Ceiling division feeds the divider with size - 1
    assign div_dividend = (req.data.size_bytes == 32'd0) ? 32'd0 :
                          req.data.size_bytes - 32'd1;

    iua_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign bin_calc = size_zero_reg ? 32'd0 : div_quot + 32'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (xfer_in)
                    state_next = (op_dec == OP_HIST_ADD) ? ST_DIV : ST_READ;
            end
            ST_DIV:   if (div_done) state_next = ST_READ;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: if (wr_go) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready   = 1'b0;
        div_start  = 1'b0;
        mem_re     = 1'b0;
        wr_go      = 1'b0;
        clr_active = 1'b0;
        case (state_reg)
            ST_CLEAR: clr_active = 1'b1;
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = req.valid && (op_dec == OP_HIST_ADD);
            end
            ST_DIV:   ;
            ST_READ:  mem_re = 1'b1;
            ST_WRITE: wr_go = !out_valid_reg || rsp.ready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // Latch the decoded request, then the bin once the divider finishes
    always_ff @(posedge clk)
    begin
        if (xfer_in)
        begin
            op_reg         <= op_dec;
            own_addr_reg   <= (op_dec == OP_OWNER_READ) ? req.data.read_index[OWN_AW-1:0] :
                                                          req.data.owner_id[OWN_AW-1:0];
            bin_addr_reg   <= req.data.read_index[BIN_AW-1:0];
            add_blocks_reg <= ((req.data.file_type & IFMT) inside {IFCHR, IFBLK}) ?
                              24'd0 : req.data.allocated_blocks;
            size_zero_reg  <= (req.data.size_bytes == 32'd0);
            bin_ovf_reg    <= 1'b0;
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            bin_val_reg  <= bin_calc;
            bin_ovf_reg  <= (bin_calc >= 32'(HIST_BINS));
            bin_addr_reg <= (bin_calc >= 32'(HIST_BINS)) ? BIN_AW'(HIST_BINS - 1) :
                                                           bin_calc[BIN_AW-1:0];
        end
    end

    // Owner memory: {file count, block total} per owner
    logic [63:0]       own_mem [OWNER_SLOTS];
    logic [63:0]       own_rd_reg;
    logic              own_we;
    logic [OWN_AW-1:0] own_wa;
    logic [63:0]       own_wd;

    // Bin memory
    logic [31:0]       bin_mem [HIST_BINS];
    logic [31:0]       bin_rd_reg;
    logic              bin_we;
    logic [BIN_AW-1:0] bin_wa;
    logic [31:0]       bin_wd;

    logic [31:0] new_blocks;
    logic [31:0] new_files;
    logic [31:0] new_bin;

    assign new_blocks = sat_add32(own_rd_reg[31:0], {8'd0, add_blocks_reg});
    assign new_files  = sat_add32(own_rd_reg[63:32], 32'd1);
    assign new_bin    = sat_add32(bin_rd_reg, 32'd1);

    // Write-back and clearing pass share one write port per memory
    always_comb
    begin
        if (clr_active)
        begin
            own_we = ({{(32-CLR_W){1'b0}}, clr_reg} < 32'(OWNER_SLOTS));
            own_wa = clr_reg[OWN_AW-1:0];
            own_wd = '0;
            bin_we = ({{(32-CLR_W){1'b0}}, clr_reg} < 32'(HIST_BINS));
            bin_wa = clr_reg[BIN_AW-1:0];
            bin_wd = '0;
        end
        else
        begin
            own_we = wr_go && (op_reg == OP_OWNER_ADD);
            own_wa = own_addr_reg;
            own_wd = {new_files, new_blocks};
            bin_we = wr_go && (op_reg == OP_HIST_ADD);
            bin_wa = bin_addr_reg;
            bin_wd = new_bin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
            own_mem[own_wa] <= own_wd;
        if (mem_re)
            own_rd_reg <= own_mem[own_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_wa] <= bin_wd;
        if (mem_re)
            bin_rd_reg <= bin_mem[bin_addr_reg];
    end

    // Oversize block sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_sum_reg <= '0;
        else if (wr_go && op_reg == OP_HIST_ADD && bin_ovf_reg)
            ovf_sum_reg <= sat_add32(ovf_sum_reg, bin_val_reg);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (wr_go)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Result fields for the request in flight
    always_comb
    begin
        out_next = '0;
        case (op_reg)
            OP_OWNER_ADD,
            OP_HIST_ADD:   out_next.status = ST_COUNTED;
            OP_OWNER_READ:
            begin
                out_next.status             = ST_VALID;
                out_next.block_or_bin_count = own_rd_reg[31:0];
                out_next.file_count         = own_rd_reg[63:32];
            end
            OP_BIN_READ:
            begin
                out_next.status             = ST_VALID;
                out_next.block_or_bin_count = bin_rd_reg;
                out_next.overflow_total     = ovf_sum_reg;
            end
            OP_RANGE:      out_next.status = ST_RANGE;
            default:       out_next.status = ST_SKIPPED;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
            out_reg <= out_next;
    end

    assign req.ready = in_ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Checks
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !rsp.valid)
        else $error("result presented during clearing pass");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg) == ST_WRITE)
        else $error("result appeared without a write-back step");

    a_single_table_update: assert property (@(posedge clk) disable iff (!rst_n)
        (own_we && bin_we) |-> clr_active)
        else $error("owner and bin tables updated by one request");

    a_ovf_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ovf_sum_reg >= $past(ovf_sum_reg))
        else $error("oversize sum decreased");

endmodule

// ===== test/tb_inode_usage_accounting.sv =====
// Testbench for the inode usage accounting block: owner tables, size histogram and readouts.
`timescale 1ns / 1ps

module tb_inode_usage_accounting;
    import iua_pkg::*;

    localparam int OWNER_SLOTS = 4096;
    localparam int HIST_BINS = 512;
    localparam int BLOCK_BYTES = 512;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS = 230;
    localparam int NUM_PHASES = 8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [23:0] MAX_BLOCKS = 24'hFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    iua_req_if req_ch ();
    iua_rsp_if rsp_ch ();

    inode_usage_accounting #(
        .OWNER_SLOTS(OWNER_SLOTS),
        .HIST_BINS(HIST_BINS),
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // Mirror of the usage tables and configuration
    logic [31:0] owner_blocks [OWNER_SLOTS];
    logic [31:0] owner_files [OWNER_SLOTS];
    logic [31:0] bin_counts [HIST_BINS];
    logic [31:0] oversize_sum;
    logic        hist_mode;
    logic        age_on;
    logic [31:0] age_limit;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    int send_gap;
    int recv_gap;
    int hold_left;
    bit hold_request;
    bit no_idle;
    int fail_count;
    int idle_cycles;
    int n_requests;
    int n_counted;
    int n_skipped;
    int n_readouts;
    int n_range;
    bit owner_sat_seen;
    bit oversize_sat_seen;

    always #5 clk = ~clk;

    function automatic logic [31:0] add_clamped(logic [31:0] acc, logic [63:0] inc);
        logic [63:0] total;
        total = {32'd0, acc} + inc;
        return (total > {32'd0, ALL_ONES}) ? ALL_ONES : total[31:0];
    endfunction

    // Apply one request to the mirrored tables and return the result it must produce
    function automatic rsp_t account_request(req_t r);
        rsp_t res;
        logic [63:0] bin;
        logic [23:0] blocks;
        res = '0;
        res.status = ST_SKIPPED;
        case (r.req_type)
            REQ_ACCOUNT:
            begin
                if (r.file_type != FT_FREE && !(age_on && r.access_time > age_limit))
                begin
                    if (hist_mode)
                    begin
                        if (r.file_type == IFDIR || r.file_type == IFREG)
                        begin
                            bin = ({32'd0, r.size_bytes} + 64'(BLOCK_BYTES - 1))
                                  / 64'(BLOCK_BYTES);
                            if (bin >= 64'(HIST_BINS))
                            begin
                                oversize_sum = add_clamped(oversize_sum, bin);
                                if (oversize_sum == ALL_ONES)
                                    oversize_sat_seen = 1'b1;
                                bin = 64'(HIST_BINS - 1);
                            end
                            bin_counts[int'(bin)] = add_clamped(bin_counts[int'(bin)], 64'd1);
                            res.status = ST_COUNTED;
                        end
                    end
                    else if (r.owner_id < OWNER_SLOTS)
                    begin
                        // devices own no data blocks
                        blocks = (r.file_type == IFCHR || r.file_type == IFBLK) ?
                                 24'd0 : r.allocated_blocks;
                        owner_blocks[r.owner_id] = add_clamped(owner_blocks[r.owner_id],
                                                               {40'd0, blocks});
                        owner_files[r.owner_id] = add_clamped(owner_files[r.owner_id], 64'd1);
                        if (owner_blocks[r.owner_id] == ALL_ONES)
                            owner_sat_seen = 1'b1;
                        res.status = ST_COUNTED;
                    end
                end
            end
            REQ_OWNER_READ:
            begin
                if (r.read_index < OWNER_SLOTS)
                begin
                    res.status = ST_VALID;
                    res.block_or_bin_count = owner_blocks[r.read_index];
                    res.file_count = owner_files[r.read_index];
                end
                else
                    res.status = ST_RANGE;
            end
            REQ_BIN_READ:
            begin
                if (r.read_index < HIST_BINS)
                begin
                    res.status = ST_VALID;
                    res.block_or_bin_count = bin_counts[r.read_index];
                    res.overflow_total = oversize_sum;
                end
                else
                    res.status = ST_RANGE;
            end
            default: ;
        endcase
        case (res.status)
            ST_COUNTED: n_counted++;
            ST_SKIPPED: n_skipped++;
            ST_VALID: n_readouts++;
            default: n_range++;
        endcase
        return res;
    endfunction

    function automatic req_t make_request(logic [1:0] kind, logic [3:0] ftype,
                                          logic [15:0] owner, logic [31:0] size,
                                          logic [31:0] atime, logic [23:0] blocks,
                                          logic [15:0] idx);
        req_t r;
        r.req_type = kind;
        r.file_type = ftype;
        r.owner_id = owner;
        r.size_bytes = size;
        r.access_time = atime;
        r.allocated_blocks = blocks;
        r.read_index = idx;
        return r;
    endfunction

    // Largest files and block counts, always inside the age window, to drive counters to the top
    function automatic req_t hammer_request();
        return make_request(REQ_ACCOUNT, $urandom_range(0, 1) ? IFREG : IFDIR, 16'd0,
                            ALL_ONES - 32'($urandom_range(0, BLOCK_BYTES - 2)), 32'd0,
                            MAX_BLOCKS - 24'($urandom_range(0, 3)), 16'($urandom));
    endfunction

    function automatic req_t random_request();
        req_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            r.req_type = REQ_ACCOUNT;
        else if (pick < 78)
            r.req_type = REQ_OWNER_READ;
        else if (pick < 94)
            r.req_type = REQ_BIN_READ;
        else
            r.req_type = REQ_UNUSED;

        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.file_type = pick[0] ? IFDIR : IFREG;
        else if (pick < 70)
            r.file_type = pick[0] ? IFCHR : IFBLK;
        else if (pick < 80)
            r.file_type = FT_FREE;
        else
            r.file_type = 4'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.owner_id = 16'($urandom_range(0, 3));
        else if (pick < 85)
            r.owner_id = 16'($urandom_range(0, OWNER_SLOTS - 1));
        else
            r.owner_id = 16'($urandom);

        // sizes cluster at the small bins and around the last bin
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.size_bytes = 32'($urandom_range(0, 4 * BLOCK_BYTES));
        else if (pick < 70)
            r.size_bytes = 32'($urandom_range((HIST_BINS - 3) * BLOCK_BYTES,
                                              (HIST_BINS + 2) * BLOCK_BYTES));
        else if (pick < 85)
            r.size_bytes = $urandom;
        else
            r.size_bytes = ALL_ONES - 32'($urandom_range(0, 2 * BLOCK_BYTES));

        // access times just around the cutoff, or anywhere
        if ($urandom_range(0, 99) < 40)
            r.access_time = age_limit + 32'($urandom_range(0, 2)) - 32'd1;
        else
            r.access_time = $urandom;

        r.allocated_blocks = ($urandom_range(0, 99) < 40) ? MAX_BLOCKS : 24'($urandom);

        pick = $urandom_range(0, 99);
        if (r.req_type == REQ_OWNER_READ)
        begin
            if (pick < 55)
                r.read_index = 16'($urandom_range(0, 3));
            else if (pick < 70)
                r.read_index = 16'($urandom_range(OWNER_SLOTS - 2, OWNER_SLOTS + 1));
            else if (pick < 85)
                r.read_index = 16'($urandom_range(0, OWNER_SLOTS - 1));
            else
                r.read_index = 16'($urandom);
        end
        else if (r.req_type == REQ_BIN_READ)
        begin
            if (pick < 40)
                r.read_index = 16'($urandom_range(0, 3));
            else if (pick < 60)
                r.read_index = 16'($urandom_range(HIST_BINS - 2, HIST_BINS + 1));
            else if (pick < 85)
                r.read_index = 16'($urandom_range(0, HIST_BINS - 1));
            else
                r.read_index = 16'($urandom);
        end
        else
            r.read_index = 16'($urandom);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_HIST_MODE: hist_mode = value[0];
            CFG_AGE_FILTER: age_on = value[0];
            CFG_AGE_CUTOFF: age_limit = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int ph);
        logic        mode;
        logic        filt;
        logic [31:0] cut;
        int          hammer_left;
        int          slots_left;
        mode = ph[0];
        filt = (ph >= 2 && ph <= 5);
        hammer_left = (ph == 6) ? 0 : (mode ? 130 : 100);
        case (ph)
            2: cut = 32'd0;
            3, 6: cut = ALL_ONES;
            7: cut = 32'd0;
            default: cut = $urandom;
        endcase
        write_cfg(CFG_HIST_MODE, {31'd0, mode});
        write_cfg(CFG_AGE_FILTER, {31'd0, filt});
        write_cfg(CFG_AGE_CUTOFF, cut);
        @(negedge clk);
        if (ph == NUM_PHASES - 1)
            no_idle = 1'b1;
        // spread the saturating items evenly at random over the phase
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            slots_left = PHASE_ITEMS - i;
            if ($urandom_range(0, slots_left - 1) < hammer_left)
            begin
                pending_reqs.push_back(hammer_request());
                hammer_left--;
            end
            else
                pending_reqs.push_back(random_request());
        end
        if (ph == 3)
            hold_request = 1'b1;
        wait_idle();
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
            send_gap = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 7);
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data <= pending_reqs.pop_front();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result ready: random bursts, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 7);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor: check results, predict accepted requests, watch for a hang
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, rsp_ch.data);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("status", {30'd0, want.status}, {30'd0, rsp_ch.data.status});
                    check_field("block_or_bin_count", want.block_or_bin_count,
                                rsp_ch.data.block_or_bin_count);
                    check_field("file_count", want.file_count, rsp_ch.data.file_count);
                    check_field("overflow_total", want.overflow_total,
                                rsp_ch.data.overflow_total);
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.push_back(account_request(req_ch.data));
                n_requests++;
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        foreach (owner_blocks[i])
        begin
            owner_blocks[i] = '0;
            owner_files[i] = '0;
        end
        foreach (bin_counts[i])
            bin_counts[i] = '0;
        oversize_sum = '0;
        hist_mode = 1'b0;
        age_on = 1'b0;
        age_limit = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: owner mode, file types, table bounds, unused request code
        write_cfg(CFG_HIST_MODE, 32'd0);
        write_cfg(CFG_AGE_FILTER, 32'd0);
        write_cfg(CFG_AGE_CUTOFF, ALL_ONES);
        @(negedge clk);
        pending_reqs.push_back(make_request(REQ_ACCOUNT, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            MAX_BLOCKS, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd0, ALL_ONES, ALL_ONES,
                                            MAX_BLOCKS, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFCHR, 16'd0, 32'd0, 32'd0,
                                            24'd5, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFBLK, 16'(OWNER_SLOTS - 1), 32'd0,
                                            32'd0, MAX_BLOCKS, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFDIR, 16'(OWNER_SLOTS - 1), 32'd0,
                                            32'd0, 24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFMT, 16'(OWNER_SLOTS - 1), 32'd0,
                                            32'd0, 24'd1, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'(OWNER_SLOTS), 32'd0,
                                            32'd0, 24'd7, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'hFFFF, 32'd0, 32'd0,
                                            24'd7, 16'd0));
        pending_reqs.push_back(make_request(REQ_OWNER_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_OWNER_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'(OWNER_SLOTS - 1)));
        pending_reqs.push_back(make_request(REQ_OWNER_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'(OWNER_SLOTS)));
        pending_reqs.push_back(make_request(REQ_OWNER_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'hFFFF));
        pending_reqs.push_back(make_request(REQ_UNUSED, IFMT, 16'hFFFF, ALL_ONES, ALL_ONES,
                                            MAX_BLOCKS, 16'hFFFF));
        wait_idle();

        // Directed: histogram bins, last bin and overflow, readouts in both kinds
        write_cfg(CFG_HIST_MODE, 32'd1);
        @(negedge clk);
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFDIR, 16'd0, 32'd1, 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd0,
                                            32'((HIST_BINS - 1) * BLOCK_BYTES), 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd0,
                                            32'((HIST_BINS - 1) * BLOCK_BYTES + 1), 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd0, ALL_ONES, 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFCHR, 16'd0, 32'd10, 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_BIN_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'd0));
        pending_reqs.push_back(make_request(REQ_BIN_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'(HIST_BINS - 1)));
        pending_reqs.push_back(make_request(REQ_BIN_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'(HIST_BINS)));
        pending_reqs.push_back(make_request(REQ_BIN_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'hFFFF));
        pending_reqs.push_back(make_request(REQ_OWNER_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'd0));
        wait_idle();

        // Directed: age filter right at the cutoff and one past it
        write_cfg(CFG_HIST_MODE, 32'd0);
        write_cfg(CFG_AGE_FILTER, 32'd1);
        write_cfg(CFG_AGE_CUTOFF, 32'd1000);
        @(negedge clk);
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd5, 32'd0, 32'd1000,
                                            24'd3, 16'd0));
        pending_reqs.push_back(make_request(REQ_ACCOUNT, IFREG, 16'd5, 32'd0, 32'd1001,
                                            24'd9, 16'd0));
        pending_reqs.push_back(make_request(REQ_OWNER_READ, FT_FREE, 16'd0, 32'd0, 32'd0,
                                            24'd0, 16'd5));
        wait_idle();

        // Random phases over the mode, filter and cutoff settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
            run_phase(ph);

        $display("Covered %0d requests over %0d settings: %0d counted, %0d skipped,",
                 n_requests, NUM_PHASES + 3, n_counted, n_skipped);
        $display("%0d reads, %0d out of range; owner block total saturation %s, %s %s.",
                 n_readouts, n_range, owner_sat_seen ? "reached" : "not reached",
                 "oversize sum saturation", oversize_sat_seen ? "reached" : "not reached");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/iua_pkg.sv
hdl/iua_if.sv
hdl/iua_div.sv
hdl/inode_usage_accounting.sv
test/tb_inode_usage_accounting.sv
